/* sv/dpst_pkg.sv */
// dpst_pkg: shared types and codes for the debounced press sequence trigger
// payload structs, configuration struct, event, op and register index codes
// no dependencies
package dpst_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 4;
  localparam int unsigned EventW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  // op codes
  localparam logic OP_PRESS = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  // event codes
  localparam logic [EventW-1:0] EV_NONE    = 3'd0;
  localparam logic [EventW-1:0] EV_PRESS   = 3'd1;
  localparam logic [EventW-1:0] EV_TIMEOUT = 3'd2;
  localparam logic [EventW-1:0] EV_STOPPED = 3'd3;
  localparam logic [EventW-1:0] EV_TRIGGER = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_CUTOFF   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESSES  = 2'd2;

  // register reset values
  localparam logic [TimeW-1:0]  CUTOFF_RST   = 32'd3000000;
  localparam logic [CountW-1:0] DEBOUNCE_RST = 4'd2;
  localparam logic [CountW-1:0] PRESSES_RST  = 4'd3;

  typedef struct packed {
    logic              op;
    logic [TimeW-1:0]  now_time;
    logic              key_level;
    logic              button_released;
  } in_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic              running;
  } out_t;

  typedef struct packed {
    logic [TimeW-1:0]  cutoff_time;
    logic [CountW-1:0] debounce_target;
    logic [CountW-1:0] press_target;
  } cfg_t;

endpackage

/* sv/dpst_core.sv */
// dpst_core: session state registers and the single-pass update for one beat
// depends on dpst_pkg
module dpst_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  dpst_pkg::in_t  item_i,
  input  dpst_pkg::cfg_t cfg_i,
  output dpst_pkg::out_t res_o,
  output logic          active_o
);
  import dpst_pkg::*;

  logic              active_q, active_d;
  logic [TimeW-1:0]  stamp_q, stamp_d;
  logic              level_q, level_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] tally_q, tally_d;

  logic              start, poll;
  logic              eff_level;
  logic [CountW-1:0] eff_count, eff_tally;
  logic [CountW-1:0] count_inc, tally_inc;
  logic [TimeW-1:0]  elapsed;
  logic              timed_out;
  logic [EventW-1:0] ev;

  assign start     = (item_i.op == OP_PRESS) && !active_q;
  assign poll      = (item_i.op == OP_POLL) && active_q;
  // a new session loads its state before the same beat is evaluated
  assign eff_level = start ? item_i.key_level : level_q;
  assign eff_count = start ? cfg_i.debounce_target : count_q;
  assign eff_tally = start ? '0 : tally_q;
  assign count_inc = eff_count + CountW'(1);
  assign tally_inc = eff_tally + CountW'(1);
  assign elapsed   = item_i.now_time - stamp_q;
  assign timed_out = poll && (elapsed > cfg_i.cutoff_time);

  always_comb begin
    active_d = active_q;
    stamp_d  = start ? item_i.now_time : stamp_q;
    level_d  = eff_level;
    count_d  = eff_count;
    tally_d  = eff_tally;
    ev       = EV_NONE;
    if (start || poll) begin
      active_d = 1'b1;
      if (timed_out) begin
        active_d = 1'b0;
        ev       = (eff_tally != '0) ? EV_TIMEOUT : EV_NONE;
      end else if (item_i.button_released) begin
        active_d = 1'b0;
        ev       = (eff_tally != '0) ? EV_STOPPED : EV_NONE;
      end else if (item_i.key_level != eff_level) begin
        level_d = item_i.key_level;
        count_d = '0;
      end else if (eff_count < cfg_i.debounce_target) begin
        count_d = count_inc;
        if ((count_inc == cfg_i.debounce_target) && eff_level) begin
          tally_d = tally_inc;
          if (tally_inc != cfg_i.press_target) begin
            ev = EV_PRESS;
          end else begin
            ev       = EV_TRIGGER;
            active_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      stamp_q  <= '0;
      level_q  <= 1'b0;
      count_q  <= '0;
      tally_q  <= '0;
    end else if (step_i) begin
      active_q <= active_d;
      stamp_q  <= stamp_d;
      level_q  <= level_d;
      count_q  <= count_d;
      tally_q  <= tally_d;
    end
  end

  assign res_o.event_res = ev;
  assign res_o.running   = active_d;
  assign active_o        = active_q;

endmodule

/* sv/debounced_press_sequence_trigger_unit.sv */
// debounced_press_sequence_trigger_unit: top level with input register, output register
// and configuration registers around the session core
// depends on dpst_pkg and dpst_core
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_stall_o   in_data_i  (dpst_pkg::in_t)
//   out      source     out_valid_o / out_stall_i out_data_o (dpst_pkg::out_t)
//   cfg      sink       cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// one beat in, one beat out; a beat is held in the input register, then passes
// into the output register, and a new beat is taken every cycle while the output
// is not stalled
// the rate is set by the combinational session update (32-bit subtract and compare)
// rst_ni clears session state, both valid flags and loads the register defaults
// out_stall_i holds the output register and the input register while out_valid_o is
// high; in_stall_o rises only when the input register is full and cannot move on
module debounced_press_sequence_trigger_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  dpst_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output dpst_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [dpst_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [dpst_pkg::CfgDataW-1:0]    cfg_data_i
);
  import dpst_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cutoff_time     <= CUTOFF_RST;
      cfg_q.debounce_target <= DEBOUNCE_RST;
      cfg_q.press_target    <= PRESSES_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CUTOFF:   cfg_q.cutoff_time     <= cfg_data_i[TimeW-1:0];
        REG_DEBOUNCE: cfg_q.debounce_target <= cfg_data_i[CountW-1:0];
        REG_PRESSES:  cfg_q.press_target    <= cfg_data_i[CountW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // pipeline control
  logic in_vld_q;
  in_t  in_q;
  logic out_vld_q;
  out_t out_q;
  logic adv;        // input register beat moves into the output register
  logic in_take;    // new beat captured into the input register
  out_t res;
  logic core_active;

  assign adv     = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take || adv) begin
      in_vld_q <= in_take;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // session update happens in the same cycle the beat leaves the input register
  dpst_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .res_o    (res),
    .active_o (core_active)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv || !out_stall_i) begin
      out_vld_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // a closing event always leaves the session stopped
  a_close_not_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.event_res == EV_TRIGGER || out_q.event_res == EV_TIMEOUT ||
                  out_q.event_res == EV_STOPPED) |-> !out_q.running)
    else $error("closing event reported with session still running");

  // a counted press keeps the session alive
  a_press_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.event_res == EV_PRESS) |-> out_q.running)
    else $error("press counted on a stopped session");

  // the running flag of a fresh result matches the core state it left behind
  a_running_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_q.running == core_active))
    else $error("reported running flag disagrees with session state");

  // a held beat in the input register is not lost
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_q))
    else $error("stalled beat dropped from input register");

endmodule
